>>> hw/rtl/sitoa_pkg.sv
// Shared constants and control/status types for the signed integer to decimal text converter.
// Used by sitoa_ctrl, sitoa_dp and the top level signed_int_to_decimal_ascii.
`timescale 1ns / 1ps
`default_nettype none

package sitoa_pkg;

    localparam int VALUE_BITS_DEF = 32;

    // Binary-to-BCD conversion consumes this many magnitude bits per cycle.
    localparam int BITS_PER_STEP = 4;

    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] MINUS_SIGN = 8'h2D;

    typedef struct packed {
        logic load;        // capture the input value and clear the BCD register
        logic step;        // one conversion step
        logic locate;      // find the most significant nonzero digit
        logic emit_sign;   // send the minus sign beat
        logic emit_digit;  // send the current digit beat and move to the next one
    } t_dp_cmd;

    typedef struct packed {
        logic negative;    // captured value was negative
        logic idx_zero;    // current digit is the least significant one
        logic out_free;    // output register can take a beat this cycle
    } t_dp_status;

endpackage

`default_nettype wire

>>> hw/rtl/sitoa_ctrl.sv
// Controller state machine for the signed integer to decimal text converter.
// Depends on sitoa_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module sitoa_ctrl #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  sitoa_pkg::t_dp_status  i_status,
    output sitoa_pkg::t_dp_cmd     o_cmd
);

    localparam int STEPS  = (VALUE_BITS + sitoa_pkg::BITS_PER_STEP - 1) / sitoa_pkg::BITS_PER_STEP;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CONV   = 3'd1;
    localparam logic [2:0] ST_LOCATE = 3'd2;
    localparam logic [2:0] ST_SIGN   = 3'd3;
    localparam logic [2:0] ST_DIGITS = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = ST_LOCATE;
                end
            end
            ST_LOCATE: begin
                o_cmd.locate = 1'b1;
                n_state      = i_status.negative ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.idx_zero) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/sitoa_dp.sv
// Datapath for the signed integer to decimal text converter: magnitude, shift-and-add-3
// BCD conversion, leading digit search and the output register. Depends on sitoa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sitoa_dp #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire [VALUE_BITS-1:0]   i_value,
    input  sitoa_pkg::t_dp_cmd     i_cmd,
    output sitoa_pkg::t_dp_status  o_status,
    input  wire                    i_out_ready,
    output logic                   o_out_valid,
    output logic [7:0]             o_char_code,
    output logic                   o_is_last
);

    localparam int BPS    = sitoa_pkg::BITS_PER_STEP;
    localparam int STEPS  = (VALUE_BITS + BPS - 1) / BPS;
    localparam int MAG_W  = STEPS * BPS;
    // Enough decimal digits for any VALUE_BITS-bit unsigned magnitude.
    localparam int NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W  = NDIG * 4;
    localparam int IDX_W  = $clog2(NDIG);

    logic                  r_neg;
    logic [MAG_W-1:0]      r_mag;
    logic [MAG_W-1:0]      n_mag;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_bcd;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      n_idx_loc;
    logic [VALUE_BITS-1:0] abs_value;
    logic [3:0]            cur_digit;
    logic                  r_out_valid;
    logic [7:0]            r_char;
    logic                  r_last;

    // Negating the most negative value wraps to 2^(VALUE_BITS-1), which is the
    // correct magnitude when read as unsigned.
    assign abs_value = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;

    // Four shift-and-add-3 iterations per cycle, most significant bits first.
    always_comb begin
        n_bcd = r_bcd;
        n_mag = r_mag;
        for (int j = 0; j < BPS; j++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (n_bcd[d*4 +: 4] >= 4'd5) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_mag[MAG_W-1]};
            n_mag = {n_mag[MAG_W-2:0], 1'b0};
        end
    end

    // Highest nonzero digit; zero leaves the index at the units digit.
    always_comb begin
        n_idx_loc = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] != 4'd0) begin
                n_idx_loc = IDX_W'(d);
            end
        end
    end

    assign cur_digit = r_bcd[r_idx*4 +: 4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VALUE_BITS-1];
            r_mag <= MAG_W'(abs_value);
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            r_mag <= n_mag;
            r_bcd <= n_bcd;
        end
        if (i_cmd.locate) begin
            r_idx <= n_idx_loc;
        end else if (i_cmd.emit_digit) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // Output register: holds one beat until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= sitoa_pkg::MINUS_SIGN;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= sitoa_pkg::DIGIT_ZERO | {4'b0000, cur_digit};
            r_last <= (r_idx == '0);
        end
    end

    assign o_status.negative = r_neg;
    assign o_status.idx_zero = (r_idx == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;

endmodule

`default_nettype wire

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text converter, top level.
// Input channel: i_in_valid/o_in_ready with i_value, a two's complement integer.
// Output channel: o_out_valid/i_out_ready with o_char_code and o_is_last; one beat
// per character, most significant first, a leading '-' for negative values, and
// o_is_last set on the final digit. Zero gives the single character '0'.
// Timing: after the input beat is taken, the magnitude goes through a
// shift-and-add-3 BCD converter that handles four bits per cycle, then the
// leading digit is found, then one character goes out per cycle while the
// output register can take it. The next input beat is taken in the cycle after
// the last character enters the output register, even while that character
// still waits for the receiver. A stalled receiver holds the current beat in
// the output register and the controller waits. Reset (synchronous, active
// low) returns the controller to idle and empties the output register; no
// other state survives an item.
// Depends on sitoa_pkg, sitoa_ctrl and sitoa_dp.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire [VALUE_BITS-1:0] i_value,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [7:0]           o_char_code,
    output logic                 o_is_last
);

    sitoa_pkg::t_dp_cmd    dp_cmd;
    sitoa_pkg::t_dp_status dp_status;

    sitoa_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    sitoa_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last)
    );

endmodule

`default_nettype wire

>>> sim/signed_int_to_decimal_ascii_tb.sv
// Testbench for signed_int_to_decimal_ascii: drives signed 32-bit values and checks every
// character beat against a local decimal-text predictor. Depends on sitoa_pkg and the RTL.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

    localparam int VALUE_W     = 32;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 30;

    typedef struct {
        logic [7:0]         code;
        logic               last;
        logic [VALUE_W-1:0] src;
    } t_char_beat;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [VALUE_W-1:0] i_value     = '0;
    logic               i_out_ready = 1'b0;
    wire                o_in_ready;
    wire                o_out_valid;
    wire  [7:0]         o_char_code;
    wire                o_is_last;

    t_char_beat pending_chars[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         in_idle_pct    = 0;
    int         out_stall_pct  = 0;

    signed_int_to_decimal_ascii #(.VALUE_BITS(VALUE_W)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time, pending_chars.size());
            $display("signed_int_to_decimal_ascii_tb: done, errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Builds the expected text of one number, sign first, then digits most significant first.
    function automatic void predict_text(input logic [VALUE_W-1:0] v);
        logic [7:0]         digits[$];
        logic [VALUE_W-1:0] mag;
        logic               negative;
        t_char_beat         beat;
        negative = v[VALUE_W-1];
        // The unsigned negation also covers the most negative value.
        mag = negative ? (~v + 1'b1) : v;
        do begin
            digits.push_front(sitoa_pkg::DIGIT_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (negative) begin
            digits.push_front(sitoa_pkg::MINUS_SIGN);
        end
        foreach (digits[k]) begin
            beat.code = digits[k];
            beat.last = (k == digits.size() - 1);
            beat.src  = v;
            pending_chars.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected beat, char %h last %b", $time, o_char_code, o_is_last);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                if (o_char_code !== want.code || o_is_last !== want.last) begin
                    $display("%0t: value %0d: expected char %h last %b, got char %h last %b",
                             $time, $signed(want.src), want.code, want.last,
                             o_char_code, o_is_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_text(v);
        @(negedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     n;
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                // Uniform over digit counts so short and long numbers both show up.
                n  = $urandom_range(10, 1);
                lo = (n == 1) ? 0 : 1;
                repeat (n - 1) lo = lo * 10;
                hi = (n == 1) ? 9 : lo * 10 - 1;
                if (hi > 64'd2147483647) hi = 64'd2147483647;
                mag = lo + $urandom_range(32'(hi - lo));
                return $urandom_range(1) ? VALUE_W'(-mag) : VALUE_W'(mag);
            end
            2: return VALUE_W'($urandom_range(40)) - VALUE_W'(20);
            default: begin
                // Neighbors of a power of ten, where the digit count changes.
                mag = 1;
                repeat ($urandom_range(9)) mag = mag * 10;
                mag = mag + $urandom_range(2) - 1;
                return $urandom_range(1) ? VALUE_W'(-mag) : VALUE_W'(mag);
            end
        endcase
    endfunction

    task automatic test_edge_values();
        logic [VALUE_W-1:0] edge_vals[$];
        edge_vals = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
                      32'd100, 32'd12345, -32'sd54321, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0001, 32'd1000000000, -32'sd1000000000, 32'd999999999,
                      32'h5555_5555, 32'hAAAA_AAAA};
        in_idle_pct   = 0;
        out_stall_pct = 0;
        foreach (edge_vals[k]) begin
            send_value(edge_vals[k]);
        end
    endtask

    task automatic test_random_values(input int count, input int idle_pct,
                                      input int stall_pct);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        repeat (count) begin
            send_value(random_value());
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_edge_values();
        test_random_values(52, 12, 72);
        test_random_values(52, 72, 12);
        test_random_values(52, 0, 0);
        i_in_valid <= 1'b0;

        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("signed_int_to_decimal_ascii_tb: done, clean");
        end else begin
            $display("signed_int_to_decimal_ascii_tb: done, errors");
        end
        $finish;
    end

endmodule
